// ===== rtl/core/tbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types, widths and helpers of the barycentric weight pipeline.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int ProdW  = 34;
  localparam int SumW   = 35;
  localparam int MagW   = 34;
  localparam int FracW  = 17;
  localparam int DvdW   = MagW + FracW;
  localparam int DvsW   = MagW + 1;
  localparam int QuoW   = DvdW;
  localparam int WgtW   = 19;
  localparam int WideW  = QuoW + 3;
  localparam int NumSteps = DvdW;

  localparam logic signed [WideW-1:0] WOne = WideW'(65536);
  localparam logic signed [WideW-1:0] WMax = WideW'(262143);
  localparam logic signed [WideW-1:0] WMin = -WideW'(262144);

  typedef enum logic [2:0] {
    REG_AX = 3'd0,
    REG_AY = 3'd1,
    REG_BX = 3'd2,
    REG_BY = 3'd3,
    REG_CX = 3'd4,
    REG_CY = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } vert_t;

  typedef struct packed {
    logic [MagW-1:0] na;
    logic [MagW-1:0] nb;
    logic [MagW-1:0] d;
    logic            neg_a;
    logic            neg_b;
    logic            degen;
  } num_t;

  typedef struct packed {
    logic [QuoW-1:0] qa;
    logic [QuoW-1:0] qb;
    logic            neg_a;
    logic            neg_b;
    logic            degen;
  } quo_t;

  function automatic logic signed [WgtW-1:0] sat_w(input logic signed [WideW-1:0] w);
    logic signed [WideW-1:0] t;
    t = w;
    if (w > WMax) t = WMax;
    if (w < WMin) t = WMin;
    return t[WgtW-1:0];
  endfunction

endpackage

// ===== rtl/core/tbc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_front
// Three stages: coordinate differences, products, edge sums with magnitudes.
// ----------------------------------------------------------------------------
module tbc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  tbc_pkg::vert_t                vert_i,
  input  logic signed [tbc_pkg::CoordW-1:0] px_i,
  input  logic signed [tbc_pkg::CoordW-1:0] py_i,
  output logic                          vld_o,
  output tbc_pkg::num_t                 num_o
);
  import tbc_pkg::*;

  logic [2:0] vld_q;
  logic signed [DiffW-1:0] px_q, py_q, dybc_q, dxcb_q, dxac_q, dyac_q;
  logic signed [ProdW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  num_t num_q, num_d;
  logic signed [SumW-1:0] sa, sb, sd, ma, mb, md;

  function automatic logic signed [DiffW-1:0] sub(input logic signed [CoordW-1:0] a,
                                                  input logic signed [CoordW-1:0] b);
    return DiffW'(a) - DiffW'(b);
  endfunction

  always_comb begin
    sa = SumW'(p1_q) + SumW'(p2_q);
    sb = SumW'(p4_q) - SumW'(p3_q);
    sd = SumW'(p5_q) + SumW'(p6_q);
    ma = sa[SumW-1] ? -sa : sa;
    mb = sb[SumW-1] ? -sb : sb;
    md = sd[SumW-1] ? -sd : sd;
    num_d.na    = ma[MagW-1:0];
    num_d.nb    = mb[MagW-1:0];
    num_d.d     = md[MagW-1:0];
    num_d.neg_a = sa[SumW-1] ^ sd[SumW-1];
    num_d.neg_b = sb[SumW-1] ^ sd[SumW-1];
    num_d.degen = (sd == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= sub(px_i, vert_i.cx);
      py_q   <= sub(py_i, vert_i.cy);
      dybc_q <= sub(vert_i.by, vert_i.cy);
      dxcb_q <= sub(vert_i.cx, vert_i.bx);
      dxac_q <= sub(vert_i.ax, vert_i.cx);
      dyac_q <= sub(vert_i.ay, vert_i.cy);
      p1_q   <= dybc_q * px_q;
      p2_q   <= dxcb_q * py_q;
      p3_q   <= dyac_q * px_q;
      p4_q   <= dxac_q * py_q;
      p5_q   <= dybc_q * dxac_q;
      p6_q   <= dxcb_q * dyac_q;
      num_q  <= num_d;
    end
  end

  assign vld_o = vld_q[2];
  assign num_o = num_q;

endmodule

// ===== rtl/core/tbc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_div
// Pipelined restoring divider, one quotient bit per stage, two lanes that
// share one divisor. Quotient is (n * 2^17 + d) / (2 * d).
// ----------------------------------------------------------------------------
module tbc_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  tbc_pkg::num_t num_i,
  output logic          vld_o,
  output tbc_pkg::quo_t quo_o
);
  import tbc_pkg::*;

  logic [NumSteps:0]  vld_q;
  logic [DvsW-1:0]    dvs_q  [0:NumSteps];
  logic [DvsW-1:0]    rema_q [0:NumSteps];
  logic [DvsW-1:0]    remb_q [0:NumSteps];
  logic [DvdW-1:0]    wrka_q [0:NumSteps];
  logic [DvdW-1:0]    wrkb_q [0:NumSteps];
  logic [2:0]         flg_q  [0:NumSteps];

  function automatic logic [DvsW+DvdW-1:0] step(input logic [DvsW-1:0] rem,
                                                input logic [DvdW-1:0] wrk,
                                                input logic [DvsW-1:0] dvs);
    logic [DvsW:0] sh;
    logic          ge;
    logic [DvsW:0] nr;
    sh = {rem, wrk[DvdW-1]};
    ge = (sh >= {1'b0, dvs});
    nr = ge ? (sh - {1'b0, dvs}) : sh;
    return {nr[DvsW-1:0], wrk[DvdW-2:0], ge};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumSteps-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvs_q[0]  <= {num_i.d, 1'b0};
      rema_q[0] <= '0;
      remb_q[0] <= '0;
      wrka_q[0] <= {num_i.na, {FracW{1'b0}}} + DvdW'(num_i.d);
      wrkb_q[0] <= {num_i.nb, {FracW{1'b0}}} + DvdW'(num_i.d);
      flg_q[0]  <= {num_i.neg_a, num_i.neg_b, num_i.degen};
      for (int k = 0; k < NumSteps; k++) begin
        {rema_q[k+1], wrka_q[k+1]} <= step(rema_q[k], wrka_q[k], dvs_q[k]);
        {remb_q[k+1], wrkb_q[k+1]} <= step(remb_q[k], wrkb_q[k], dvs_q[k]);
        dvs_q[k+1] <= dvs_q[k];
        flg_q[k+1] <= flg_q[k];
      end
    end
  end

  assign vld_o       = vld_q[NumSteps];
  assign quo_o.qa    = wrka_q[NumSteps];
  assign quo_o.qb    = wrkb_q[NumSteps];
  assign quo_o.neg_a = flg_q[NumSteps][2];
  assign quo_o.neg_b = flg_q[NumSteps][1];
  assign quo_o.degen = flg_q[NumSteps][0];

endmodule

// ===== rtl/core/tbc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_back
// Sign restore, third weight, saturation and the output register.
// ----------------------------------------------------------------------------
module tbc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  tbc_pkg::quo_t                  quo_i,
  output logic                           vld_o,
  output logic signed [tbc_pkg::WgtW-1:0] wa_o,
  output logic signed [tbc_pkg::WgtW-1:0] wb_o,
  output logic signed [tbc_pkg::WgtW-1:0] wc_o,
  output logic                           degen_o
);
  import tbc_pkg::*;

  logic vld_q;
  logic signed [WgtW-1:0] wa_q, wb_q, wc_q, wa_d, wb_d, wc_d;
  logic degen_q;
  logic signed [WideW-1:0] sa, sb, sc;

  always_comb begin
    sa = quo_i.neg_a ? -$signed({3'b000, quo_i.qa}) : $signed({3'b000, quo_i.qa});
    sb = quo_i.neg_b ? -$signed({3'b000, quo_i.qb}) : $signed({3'b000, quo_i.qb});
    sc = WOne - sa - sb;
    if (quo_i.degen) begin
      wa_d = '0;
      wb_d = '0;
      wc_d = '0;
    end else begin
      wa_d = sat_w(sa);
      wb_d = sat_w(sb);
      wc_d = sat_w(sc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wa_q    <= wa_d;
      wb_q    <= wb_d;
      wc_q    <= wc_d;
      degen_q <= quo_i.degen;
    end
  end

  assign vld_o   = vld_q;
  assign wa_o    = wa_q;
  assign wb_o    = wb_q;
  assign wc_o    = wc_q;
  assign degen_o = degen_q;

endmodule

// ===== rtl/core/triangle_barycentric_coords.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_barycentric_coords
// Barycentric weights of sample points against a triangle held in registers.
//
// Write the six vertex registers through cfg_we_i / cfg_idx_i / cfg_wdata_i
// while no transaction is in flight; indexes six and seven are ignored.
// Each slave transaction carries one point (x in bits 15:0, y in 31:16) and
// yields one master transaction with weights a, b, c in tdata and the
// degenerate flag in tuser.
// The pipeline has three front stages, one divider load stage, 51 one-bit
// divider stages and the output register. One transaction enters per cycle
// unless the receiver stalls; the 51-stage restoring divider sets the depth.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and s_axis_tready drops.
// Reset clears the vertices to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module triangle_barycentric_coords (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // point_x, point_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // weight_a, weight_b, weight_c, zero pad
  output logic        m_axis_tuser    // degenerate
);
  import tbc_pkg::*;

  vert_t vert_q;
  logic  en;
  logic  f_vld, d_vld, b_vld;
  num_t  num;
  quo_t  quo;
  logic signed [WgtW-1:0] wa, wb, wc;
  logic  degen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AX:  vert_q.ax <= cfg_wdata_i;
        REG_AY:  vert_q.ay <= cfg_wdata_i;
        REG_BX:  vert_q.bx <= cfg_wdata_i;
        REG_BY:  vert_q.by <= cfg_wdata_i;
        REG_CX:  vert_q.cx <= cfg_wdata_i;
        REG_CY:  vert_q.cy <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en            = !b_vld || m_axis_tready;
  assign s_axis_tready = en;

  tbc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .vert_i (vert_q),
    .px_i   (s_axis_tdata[15:0]),
    .py_i   (s_axis_tdata[31:16]),
    .vld_o  (f_vld),
    .num_o  (num)
  );

  tbc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld),
    .num_i  (num),
    .vld_o  (d_vld),
    .quo_o  (quo)
  );

  tbc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (d_vld),
    .quo_i   (quo),
    .vld_o   (b_vld),
    .wa_o    (wa),
    .wb_o    (wb),
    .wc_o    (wc),
    .degen_o (degen)
  );

  assign m_axis_tvalid = b_vld;
  assign m_axis_tdata  = {7'b0, wc, wb, wa};
  assign m_axis_tuser  = degen;

endmodule
